// ===== design/cbq_pkg.sv =====
package cbq_pkg;

    localparam int SECTIONS      = 8;
    localparam int COEFS_PER_SEC = 5;
    localparam int SLOTS         = COEFS_PER_SEC * SECTIONS + 1;
    localparam int GAIN_SLOT     = COEFS_PER_SEC * SECTIONS;
    localparam int COEF_AW       = $clog2(SLOTS);
    localparam int SEC_AW        = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [23:0] sample_in;
        logic [5:0]         coeff_index;
        logic signed [31:0] coeff_value;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic signed [39:0] fd;
        logic signed [39:0] sd;
    } delay_pair_t;

    typedef struct packed {
        logic               rd_en;
        logic [COEF_AW-1:0] rd_addr;
        logic               wr_en;
        logic [COEF_AW-1:0] wr_addr;
        logic signed [31:0] wr_data;
    } coef_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [SEC_AW-1:0] rd_addr;
        logic              wr_en;
        logic [SEC_AW-1:0] wr_addr;
        delay_pair_t       wr_data;
    } state_req_t;

    // b0 of every section and the gain slot start at one
    function automatic logic [SLOTS-1:0] neutral_mask();
        logic [SLOTS-1:0] m;
        m = '0;
        for (int s = 0; s <= SECTIONS; s++)
        begin
            m[COEFS_PER_SEC * s] = 1'b1;
        end
        return m;
    endfunction

    localparam logic [SLOTS-1:0] NEUTRAL_MASK = neutral_mask();

    // q3.28 times q8.23 product back to 28 fraction bits, round half up
    function automatic logic signed [40:0] rnd23(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd4194304;
        return $signed(t[63:23]);
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        if (v > 48'sh007F_FFFF_FFFF)
        begin
            return 40'sh7F_FFFF_FFFF;
        end
        else if (v < 48'shFF80_0000_0000)
        begin
            return 40'sh80_0000_0000;
        end
        return $signed(v[39:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < 48'shFFFF_8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return $signed(v[31:0]);
    endfunction

endpackage

// ===== design/cascaded_biquad_filter_core.sv =====
// cascaded biquad low-pass filter, transposed direct form ii, with final gain
//
// input channel (item_valid / item_stall / item): a word with command set to
// write loads one coefficient slot (b0,b1,b2,a1,a2 per section, gain last) in
// the cycle it is accepted and gives no result; slots past the gain are dropped.
// a word with command set to filter runs sample_in through all sections.
// output channel (result_valid / result_stall / result): one word per sample,
// sample_out saturated to 24 bits, saturated high when it was clipped.
// a sample runs every section through the steps rd, mul0, y, t1, t2, fd and wb
// on the single multiplier, then the gain steps rd, mul and out to result_valid.
// item_stall is high while a sample is in flight, so the next word is taken
// only once a sample leaves the gain step, or the cycle after a coefficient word.
// the coefficient memory takes at most one read per step, the delay memory one
// per section; each section reads and writes back its own delay entry, so
// accesses never overlap. the result register frees the input side: a new word
// is accepted while a result waits; if result_stall still holds it at the end
// of the next sample, the core holds in its gain step until the result is taken.
// reset: coefficients neutral (pass-through), delays zero, no result pending.
module cascaded_biquad_filter_core
    import cbq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    typedef enum logic [1:0] {ST_IDLE, ST_SEC, ST_GAIN} state_t;

    localparam logic [2:0] STEP_RD      = 3'd0;
    localparam logic [2:0] STEP_MUL0    = 3'd1;
    localparam logic [2:0] STEP_Y       = 3'd2;
    localparam logic [2:0] STEP_T1      = 3'd3;
    localparam logic [2:0] STEP_T2      = 3'd4;
    localparam logic [2:0] STEP_FD      = 3'd5;
    localparam logic [2:0] STEP_WB      = 3'd6;
    localparam logic [2:0] STEP_LAST_RD = 3'd4;
    localparam logic [2:0] GAIN_RD      = 3'd0;
    localparam logic [2:0] GAIN_MUL     = 3'd1;
    localparam logic [2:0] GAIN_OUT     = 3'd2;

    state_t              state_reg;
    logic [2:0]          step_reg;
    logic [SEC_AW-1:0]   sec_reg;
    logic [COEF_AW-1:0]  base_reg;
    logic signed [31:0]  x_reg;
    logic signed [31:0]  y_reg;
    logic signed [41:0]  t1_reg;
    logic signed [40:0]  t2_reg;
    logic signed [39:0]  fd_new_reg;
    logic                result_valid_reg;
    out_word_t           result_reg;

    coef_req_t           coef_req;
    state_req_t          st_req;
    logic signed [31:0]  coef_rdata;
    delay_pair_t         st_rdata;
    logic                mac_en;
    logic signed [31:0]  mac_operand;
    logic signed [63:0]  prod;

    logic                item_take;
    logic                out_free;
    logic                result_load;
    logic signed [40:0]  rnd;
    logic signed [41:0]  acc;
    logic signed [31:0]  y_next;
    logic signed [41:0]  t1_next;
    logic signed [39:0]  fd_next;
    logic signed [39:0]  sd_next;
    logic signed [63:0]  gain_sum;
    logic signed [35:0]  gain_q;
    logic                clip_hi;
    logic                clip_lo;
    out_word_t           result_next;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_take   = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign result_load = (state_reg == ST_GAIN) && (step_reg == GAIN_OUT) && out_free;

    always_comb
    begin
        coef_req.rd_en   = ((state_reg == ST_SEC) && (step_reg <= STEP_LAST_RD))
                        || ((state_reg == ST_GAIN) && (step_reg == GAIN_RD));
        coef_req.rd_addr = base_reg + COEF_AW'(step_reg);
        coef_req.wr_en   = item_take && (item.command == CMD_WRITE)
                        && (int'(item.coeff_index) < SLOTS);
        coef_req.wr_addr = COEF_AW'(item.coeff_index);
        coef_req.wr_data = item.coeff_value;

        st_req.rd_en      = (state_reg == ST_SEC) && (step_reg == STEP_RD);
        st_req.rd_addr    = sec_reg;
        st_req.wr_en      = (state_reg == ST_SEC) && (step_reg == STEP_WB);
        st_req.wr_addr    = sec_reg;
        st_req.wr_data.fd = fd_new_reg;
        st_req.wr_data.sd = sd_next;

        mac_en = ((state_reg == ST_SEC) && (step_reg >= STEP_MUL0) && (step_reg <= STEP_FD))
              || ((state_reg == ST_GAIN) && (step_reg == GAIN_MUL));
        // b0,b1,b2 take the section input, a1,a2 and the gain take its output
        mac_operand = ((state_reg == ST_GAIN) || (step_reg >= STEP_T2)) ? y_reg : x_reg;
    end

    cbq_coef_mem u_coef_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (coef_req),
        .rdata (coef_rdata)
    );

    cbq_state_mem u_state_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (st_req),
        .rdata (st_rdata)
    );

    cbq_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (mac_en),
        .coef    (coef_rdata),
        .operand (mac_operand),
        .product (prod)
    );

    always_comb
    begin
        rnd     = rnd23(prod);
        acc     = 42'(st_rdata.fd) + 42'(rnd) + 42'sd16;
        y_next  = sat32(48'($signed(acc[41:5])));
        t1_next = 42'(st_rdata.sd) + 42'(rnd);
        fd_next = sat40(48'(t1_reg) - 48'(rnd));
        sd_next = sat40(48'(t2_reg) - 48'(rnd));

        gain_sum = prod + 64'sd134217728;
        gain_q   = $signed(gain_sum[63:28]);
        clip_hi  = gain_q > 36'sh0_007F_FFFF;
        clip_lo  = gain_q < 36'shF_FF80_0000;
        result_next.saturated = clip_hi || clip_lo;
        if (clip_hi)
        begin
            result_next.sample_out = 24'sh7F_FFFF;
        end
        else if (clip_lo)
        begin
            result_next.sample_out = 24'sh80_0000;
        end
        else
        begin
            result_next.sample_out = $signed(gain_q[23:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            sec_reg          <= '0;
            base_reg         <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            t1_reg           <= '0;
            t2_reg           <= '0;
            fd_new_reg       <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
                result_reg       <= result_next;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_take && (item.command == CMD_FILTER))
                    begin
                        state_reg <= ST_SEC;
                        step_reg  <= STEP_RD;
                        sec_reg   <= '0;
                        base_reg  <= '0;
                        x_reg     <= 32'(item.sample_in);
                    end
                end
                ST_SEC:
                begin
                    if (step_reg == STEP_WB)
                    begin
                        step_reg <= STEP_RD;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                    case (step_reg)
                        STEP_Y:  y_reg      <= y_next;
                        STEP_T1: t1_reg     <= t1_next;
                        STEP_T2: t2_reg     <= rnd;
                        STEP_FD: fd_new_reg <= fd_next;
                        STEP_WB:
                        begin
                            x_reg    <= y_reg;
                            sec_reg  <= sec_reg + SEC_AW'(1);
                            base_reg <= base_reg + COEF_AW'(COEFS_PER_SEC);
                            if (sec_reg == SEC_AW'(SECTIONS - 1))
                            begin
                                state_reg <= ST_GAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_GAIN:
                begin
                    if (step_reg == GAIN_OUT)
                    begin
                        if (result_load)
                        begin
                            state_reg <= ST_IDLE;
                            step_reg  <= '0;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_result_from_gain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_GAIN))
        else $error("result word raised outside the gain step");

    a_coef_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        coef_req.wr_en |-> (state_reg == ST_IDLE) && !coef_req.rd_en)
        else $error("coefficient write while a sample is in flight");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.command == CMD_FILTER))
        |=> (state_reg == ST_SEC) && (sec_reg == '0) && (step_reg == STEP_RD))
        else $error("accepted sample did not start at the first section");

    a_writeback_order: assert property (@(posedge clk) disable iff (!rst_n)
        st_req.wr_en |-> $past(state_reg == ST_SEC && step_reg == STEP_FD))
        else $error("delay write-back out of step order");

endmodule

// ===== design/cbq_coef_mem.sv =====
module cbq_coef_mem
    import cbq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  coef_req_t          req,
    output logic signed [31:0] rdata
);

    logic [31:0]      coef_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [31:0]      mem_q_reg;
    logic             hit_reg;
    logic             neutral_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            coef_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= coef_mem[req.rd_addr];
        end
    end

    // an entry never written reads as its neutral value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            hit_reg     <= 1'b0;
            neutral_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg     <= valid_reg[req.rd_addr];
                neutral_reg <= NEUTRAL_MASK[req.rd_addr];
            end
        end
    end

    assign rdata = hit_reg ? $signed(mem_q_reg) : (neutral_reg ? ONE_Q28 : 32'sd0);

endmodule

// ===== design/cbq_state_mem.sv =====
module cbq_state_mem
    import cbq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  state_req_t  req,
    output delay_pair_t rdata
);

    delay_pair_t      state_mem [SECTIONS];
    logic [SECTIONS-1:0] valid_reg;
    delay_pair_t      mem_q_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            state_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= state_mem[req.rd_addr];
        end
    end

    // delays start at zero until a section writes them back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = hit_reg ? mem_q_reg : '0;

endmodule

// ===== design/cbq_mac.sv =====
module cbq_mac
    import cbq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [31:0] coef,
    input  logic signed [31:0] operand,
    output logic signed [63:0] product
);

    logic signed [63:0] product_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_reg <= '0;
        end
        else if (en)
        begin
            product_reg <= 64'(coef) * 64'(operand);
        end
    end

    assign product = product_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cbq_pkg::*;

    localparam int ITEMS     = 1250;
    localparam int IDLE_MAX  = 5000;
    localparam int LONG_HOLD = 600;

    localparam longint MAX24 = 64'sd8388607;
    localparam longint MIN24 = -64'sd8388608;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam longint MAX40 = 64'sh0000_007F_FFFF_FFFF;
    localparam longint MIN40 = 64'shFFFF_FF80_0000_0000;

    typedef enum int {TAP_B0, TAP_B1, TAP_B2, TAP_A1, TAP_A2} tap_e;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_word_t  item;
    logic      result_valid;
    logic      result_stall;
    out_word_t result;

    // filter state as the chain should see it
    longint    coef_q28 [SLOTS];
    longint    z1 [SECTIONS];
    longint    z2 [SECTIONS];
    out_word_t pending_out [$];
    plan_row_t plan [$];

    int faults;
    int words_sent;
    int taken;
    int idle_cycles;

    cascaded_biquad_filter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint rnd(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // applies one word to the chain; returns 1 when it yields an output sample
    function automatic bit run_chain(input in_word_t w, output out_word_t r);
        longint x;
        longint y;
        longint acc;
        longint g;
        int     base;
        r = '0;
        if (w.command == CMD_WRITE)
        begin
            if (w.coeff_index < SLOTS)
            begin
                coef_q28[w.coeff_index] = longint'($signed(w.coeff_value));
            end
            return 1'b0;
        end
        x = longint'($signed(w.sample_in));
        y = x;
        for (int s = 0; s < SECTIONS; s++)
        begin
            base  = COEFS_PER_SEC * s;
            acc   = z1[s] + rnd(coef_q28[base + TAP_B0] * x, 23);
            y     = clip(rnd(acc, 5), MIN32, MAX32);
            z1[s] = clip(z2[s] + rnd(coef_q28[base + TAP_B1] * x, 23)
                         - rnd(coef_q28[base + TAP_A1] * y, 23), MIN40, MAX40);
            z2[s] = clip(rnd(coef_q28[base + TAP_B2] * x, 23)
                         - rnd(coef_q28[base + TAP_A2] * y, 23), MIN40, MAX40);
            x     = y;
        end
        g = rnd(coef_q28[GAIN_SLOT] * y, 28);
        r.saturated  = (g > MAX24) || (g < MIN24);
        r.sample_out = 24'(clip(g, MIN24, MAX24));
        return 1'b1;
    endfunction

    function automatic plan_row_t step_row(input logic cmd, input int smp, input int idx,
                                           input int val, input bit typed, input int out,
                                           input bit sat);
        plan_row_t r;
        r.w                   = '0;
        r.w.command           = cmd;
        r.w.sample_in         = smp[23:0];
        r.w.coeff_index       = idx[5:0];
        r.w.coeff_value       = val;
        r.typed               = typed;
        r.want.sample_out     = out[23:0];
        r.want.saturated      = sat;
        return r;
    endfunction

    function automatic in_word_t rand_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(in_word_t)-1:0];
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            2:       return 24'sh00_0000;
            3:       return 24'shFF_FFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic report_fault(input string what);
        if (faults < 10)
        begin
            $display("%s", what);
        end
        faults++;
    endtask

    // offers one word after a random gap, or none in back-to-back phases, and predicts it once taken
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t calc;
        int        gap;
        gap = ((words_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        if (run_chain(w, calc))
        begin
            pending_out.push_back(typed ? want : calc);
        end
        if (w.command == CMD_FILTER || w.coeff_index < SLOTS)
        begin
            words_sent++;
        end
    endtask

    task automatic send_sample();
        in_word_t w;
        w           = rand_word();
        w.command   = CMD_FILTER;
        w.sample_in = pick_sample();
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_coef(input int idx, input logic signed [31:0] val);
        in_word_t w;
        w             = rand_word();
        w.command     = CMD_WRITE;
        w.coeff_index = idx[5:0];
        w.coeff_value = val;
        send_word(w, 1'b0, '0);
    endtask

    // stimulus
    initial
    begin
        int kind;
        int sec;
        int lim;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        faults      = 0;
        words_sent  = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            coef_q28[k] = (k % COEFS_PER_SEC == TAP_B0) ? longint'(ONE_Q28) : 0;
        end
        for (int s = 0; s < SECTIONS; s++)
        begin
            z1[s] = 0;
            z2[s] = 0;
        end

        // pass-through after reset, gain extremes, dropped slots, feed-forward and feedback taps
        plan.push_back(step_row(CMD_FILTER, 0, 0, 0, 1, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 8388607, 0, 0, 1, 8388607, 0));
        plan.push_back(step_row(CMD_FILTER, -8388608, 0, 0, 1, -8388608, 0));
        plan.push_back(step_row(CMD_WRITE, 0, GAIN_SLOT, 32'h7FFF_FFFF, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 8388607, 0, 0, 1, 8388607, 1));
        plan.push_back(step_row(CMD_FILTER, -8388608, 0, 0, 1, -8388608, 1));
        plan.push_back(step_row(CMD_FILTER, 0, 0, 0, 1, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, GAIN_SLOT, 32'h8000_0000, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 8388607, 0, 0, 1, -8388608, 1));
        plan.push_back(step_row(CMD_FILTER, -8388608, 0, 0, 1, 8388607, 1));
        plan.push_back(step_row(CMD_WRITE, 0, SLOTS, 32'h7FFF_FFFF, 0, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, 63, 32'h7FFF_FFFF, 0, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, GAIN_SLOT, ONE_Q28, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 1, 0, 0, 1, 1, 0));
        plan.push_back(step_row(CMD_WRITE, 0, TAP_B1, 32'h0800_0000, 0, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, TAP_A1, 32'hF800_0000, 0, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, TAP_B2, 32'h0400_0000, 0, 0, 0));
        plan.push_back(step_row(CMD_WRITE, 0, TAP_A2, 32'h0200_0000, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 4000000, 0, 0, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, -3000000, 0, 0, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 0, 0, 0, 0, 0, 0));
        // huge b0 in the last section of the chain drives the output into saturation
        plan.push_back(step_row(CMD_WRITE, 0, COEFS_PER_SEC * (SECTIONS - 1) + TAP_B0,
                                32'h7FFF_FFFF, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 8388607, 0, 0, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, -8388608, 0, 0, 0, 0, 0));
        plan.push_back(step_row(CMD_FILTER, 12345, 0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            send_word(plan[i].w, plan[i].typed, plan[i].want);
        end

        while (words_sent < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // retune one to three sections with small stable taps, then stream
                repeat ($urandom_range(1, 3))
                begin
                    sec = $urandom_range(0, SECTIONS - 1);
                    for (int t = 0; t < COEFS_PER_SEC; t++)
                    begin
                        lim = (t == TAP_A1) ? (1 << 27) : (1 << 26);
                        send_coef(COEFS_PER_SEC * sec + t, $urandom_range(0, 2 * lim) - lim);
                    end
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_coef(GAIN_SLOT, $urandom_range(0, 1 << 30) - (1 << 29));
                end
                repeat ($urandom_range(15, 40)) send_sample();
            end
            else if (kind <= 7)
            begin
                repeat ($urandom_range(10, 20)) send_word(rand_word(), 1'b0, '0);
            end
            else if (kind == 8)
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    send_coef(k, (k % COEFS_PER_SEC == TAP_B0) ? ONE_Q28 : 32'sd0);
                end
                repeat ($urandom_range(10, 20)) send_sample();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 2))
                        0:       send_coef($urandom_range(0, GAIN_SLOT), 32'h7FFF_FFFF);
                        1:       send_coef($urandom_range(0, GAIN_SLOT), 32'h8000_0000);
                        default: send_coef($urandom_range(0, GAIN_SLOT), $urandom);
                    endcase
                end
                repeat ($urandom_range(10, 20)) send_sample();
            end
        end
        item_valid <= 1'b0;

        while (pending_out.size() != 0)
        begin
            @(posedge clk);
        end
        // room for a stray word: two full passes through the chain
        repeat (2 * (7 * SECTIONS + 4)) @(posedge clk);
        if (faults == 0 && pending_out.size() == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // output side
    initial
    begin
        int        n;
        out_word_t want;
        result_stall <= 1'b0;
        taken         = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken == 25)
            begin
                n = LONG_HOLD;
            end
            else if ((taken / 40) % 3 == 1)
            begin
                n = 0;
            end
            else
            begin
                n = $urandom_range(0, 5);
            end
            if (n > 0)
            begin
                // hold counted from the moment a word shows up
                result_stall <= 1'b1;
                @(posedge clk);
                while (!result_valid)
                begin
                    @(posedge clk);
                end
                repeat (n - 1) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            taken++;
            if (pending_out.size() == 0)
            begin
                report_fault($sformatf("unexpected word: sample_out=%0d saturated=%0b",
                                       result.sample_out, result.saturated));
            end
            else
            begin
                want = pending_out.pop_front();
                if (result.sample_out !== want.sample_out || result.saturated !== want.saturated)
                begin
                    report_fault($sformatf(
                        "word %0d: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                        taken, want.sample_out, result.sample_out,
                        want.saturated, result.saturated));
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_MAX)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

endmodule
